[rtl/core/positional_array_engine_assert.svh]
// assertion macros shared by the positional array engine rtl
// no dependencies; taken in by files that carry concurrent checks
`ifndef POSITIONAL_ARRAY_ENGINE_ASSERT_SVH
`define POSITIONAL_ARRAY_ENGINE_ASSERT_SVH

// same-cycle implication under the async active-low reset
`define PAE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication under the async active-low reset
`define PAE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/pae_pkg.sv]
// shared types, widths and codes for the positional array engine
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package pae_pkg;

  localparam int DEF_CAPACITY = 64;

  localparam int CMD_W     = 3;
  localparam int POS_W     = 7;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int FOUND_W   = 6;
  localparam int COUNT_W   = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_SEARCH = 3'd2,
    CMD_UPDATE = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BADPOS   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN,
    ST_OUT
  } state_e;

  // broadcast to every cell of the row
  typedef struct packed {
    logic exec;
    logic shift_up;
    logic shift_down;
    logic write;
    logic search;
    logic read;
  } cell_ctl_t;

endpackage

[rtl/core/pae_cell.sv]
// one storage cell of the array row: holds an entry, shifts with its neighbours,
// compares against the key and taps out on read; uses pae_pkg
`timescale 1ns / 1ps

module pae_cell
  import pae_pkg::*;
#(
  parameter int Idx  = 0,
  parameter int CmpW = POS_W
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [CmpW-1:0]   pos_i,
  input  logic [CmpW-1:0]   count_i,
  input  logic [DATA_W-1:0] value_i,
  input  logic [DATA_W-1:0] left_i,
  input  logic [DATA_W-1:0] right_i,
  output logic [DATA_W-1:0] entry_o,
  output logic              match_o,
  output logic [DATA_W-1:0] rd_tap_o
);

  localparam logic [CmpW-1:0] MyIdx = CmpW'(Idx);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic              match_q, match_d;
  logic              sel_q, sel_d;
  logic              at_pos, past_pos;

  assign at_pos   = (MyIdx == pos_i);
  assign past_pos = (MyIdx > pos_i);

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.exec) begin
      priority if (ctl_i.write && at_pos) begin
        entry_d = value_i;
      end else if (ctl_i.shift_up && past_pos) begin
        entry_d = left_i;
      end else if (ctl_i.shift_down && (past_pos || at_pos)) begin
        entry_d = right_i;
      end else begin
        entry_d = entry_q;
      end
    end
  end

  always_comb begin
    match_d = match_q;
    sel_d   = sel_q;
    if (ctl_i.exec) begin
      match_d = ctl_i.search && (entry_q == value_i) && (MyIdx < count_i);
      sel_d   = ctl_i.read && at_pos;
    end
  end

  // entries are undefined until written
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      sel_q   <= 1'b0;
    end else begin
      match_q <= match_d;
      sel_q   <= sel_d;
    end
  end

  assign entry_o  = entry_q;
  assign match_o  = match_q;
  assign rd_tap_o = sel_q ? entry_q : '0;

endmodule

[rtl/core/pae_ctrl.sv]
// command sequencer: bounds checks, live count, cell control, result register
// uses pae_pkg and the assertion macros header
`timescale 1ns / 1ps

`include "positional_array_engine_assert.svh"

module pae_ctrl
  import pae_pkg::*;
#(
  parameter int Capacity = DEF_CAPACITY,
  parameter int CmpW     = POS_W
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    in_cmd_i,
  input  logic [POS_W-1:0]    in_position_i,
  input  logic [DATA_W-1:0]   in_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [FOUND_W-1:0]  out_found_index_o,
  output logic [DATA_W-1:0]   out_read_value_o,
  output logic [COUNT_W-1:0]  out_entry_count_o,
  output cell_ctl_t           ctl_o,
  output logic [CmpW-1:0]     pos_o,
  output logic [CmpW-1:0]     count_o,
  output logic [DATA_W-1:0]   value_o,
  input  logic [Capacity-1:0] match_i,
  input  logic [DATA_W-1:0]   rd_word_i
);

  localparam int CntW = $clog2(Capacity + 1);
  localparam int IdxW = (Capacity > 2) ? $clog2(Capacity) : 1;

  state_e state_q, state_d;
  logic   in_xfer, out_xfer, exec;

  logic [CntW-1:0]     count_q, count_d;
  logic [CMD_W-1:0]    cmd_q;
  logic [CmpW-1:0]     pos_q;
  logic [DATA_W-1:0]   val_q;
  logic [STATUS_W-1:0] chk_q, chk_d;
  logic                go_q, go_d;

  logic [STATUS_W-1:0] status_q;
  logic [FOUND_W-1:0]  found_q;
  logic [DATA_W-1:0]   rdval_q;
  logic [COUNT_W-1:0]  cnt_out_q;

  logic [CmpW-1:0]     in_pos_ext, cnt_ext;
  logic                full;
  logic [Capacity-1:0] lowest;
  logic [IdxW-1:0]     hit_idx;
  logic                hit;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_xfer) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_FIN;
      ST_FIN:  state_d = ST_OUT;
      ST_OUT:  if (out_xfer) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    exec        = 1'b0;
    unique case (state_q)
      ST_IDLE: in_stall_o  = 1'b0;
      ST_EXEC: exec        = 1'b1;
      ST_FIN:  ;
      ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // bounds checks at accept time
  assign in_pos_ext = CmpW'(in_position_i);
  assign cnt_ext    = CmpW'(count_q);
  assign full       = (count_q == CntW'(Capacity));

  always_comb begin
    chk_d = STAT_OK;
    go_d  = 1'b0;
    unique case (in_cmd_i)
      CMD_INSERT: begin
        priority if (full) chk_d = STAT_FULL;
        else if (in_pos_ext > cnt_ext) chk_d = STAT_BADPOS;
        else go_d = 1'b1;
      end
      CMD_DELETE, CMD_UPDATE, CMD_READ: begin
        if (in_pos_ext >= cnt_ext) chk_d = STAT_BADPOS;
        else go_d = 1'b1;
      end
      CMD_SEARCH: go_d = 1'b1;
      default:    go_d = 1'b0;
    endcase
  end

  always_comb begin
    ctl_o            = '0;
    ctl_o.exec       = exec;
    ctl_o.shift_up   = go_q && (cmd_q == CMD_INSERT);
    ctl_o.shift_down = go_q && (cmd_q == CMD_DELETE);
    ctl_o.write      = go_q && ((cmd_q == CMD_INSERT) || (cmd_q == CMD_UPDATE));
    ctl_o.search     = go_q && (cmd_q == CMD_SEARCH);
    ctl_o.read       = go_q && (cmd_q == CMD_READ);
  end

  assign pos_o   = pos_q;
  assign count_o = cnt_ext;
  assign value_o = val_q;

  always_comb begin
    count_d = count_q;
    if (exec && go_q && (cmd_q == CMD_INSERT)) begin
      count_d = count_q + CntW'(1);
    end else if (exec && go_q && (cmd_q == CMD_DELETE)) begin
      count_d = count_q - CntW'(1);
    end
  end

  // lowest matching cell: isolate the least significant set bit
  assign lowest = match_i & (~match_i + Capacity'(1));
  assign hit    = |match_i;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < Capacity; i++) begin
      if (lowest[i]) hit_idx = hit_idx | IdxW'(i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      go_q    <= 1'b0;
      cmd_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (in_xfer) begin
        go_q  <= go_d;
        cmd_q <= in_cmd_i;
      end
    end
  end

  // command payload and result registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      pos_q <= in_pos_ext;
      val_q <= in_value_i;
      chk_q <= chk_d;
    end
    if (state_q == ST_FIN) begin
      if (go_q && (cmd_q == CMD_SEARCH) && !hit) begin
        status_q <= STAT_NOTFOUND;
      end else begin
        status_q <= chk_q;
      end
      found_q   <= (ctl_o.search && hit) ? FOUND_W'(hit_idx) : '0;
      rdval_q   <= ctl_o.read ? rd_word_i : '0;
      cnt_out_q <= COUNT_W'(count_q);
    end
  end

  assign out_status_o      = status_q;
  assign out_found_index_o = found_q;
  assign out_read_value_o  = rdval_q;
  assign out_entry_count_o = cnt_out_q;

  `PAE_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(Capacity), "live count above capacity")
  `PAE_ASSERT_NEXT(a_latency, clk_i, rst_ni, in_xfer, ##2 out_valid_o, "result not ready three cycles after accept")
  `PAE_ASSERT_NEXT(a_count_hold, clk_i, rst_ni, state_q != ST_EXEC, $stable(count_q), "live count moved outside execute")
  `PAE_ASSERT_IMPL(a_notfound_src, clk_i, rst_ni, out_valid_o && (out_status_o == STAT_NOTFOUND), cmd_q == CMD_SEARCH, "not-found status on a non-search command")

endmodule

[rtl/core/positional_array_engine.sv]
// positional array engine top level: row of storage cells plus the sequencer
// uses pae_pkg, pae_cell and pae_ctrl
`timescale 1ns / 1ps

// Usage
// Input channel: in_valid_i / in_stall_o carry one command (in_cmd_i, in_position_i,
// in_value_i); a transfer happens on a clock edge with valid high and stall low.
// Output channel: out_valid_o / out_stall_i carry one result per command (status,
// found index, read value, live entry count after the command).
// After its input transfer each command passes through the sequencer states in order:
// an execute state in which every cell shifts, writes or compares in parallel, a finish
// state that encodes the lowest match and collects the read tap into the result
// register, then an output state with the result offered. The sequencer handles one
// command at a time and takes the next one the cycle after the result transfer, so it
// accepts no new command until the result of the last one has been transferred.
// While the receiver stalls, the result holds steady and no new command is taken.
// Reset (rst_ni low, asynchronous) clears the live count and the sequencer; entry
// contents are undefined until written, and only live entries are ever read.
// Unused command codes return ok with the count unchanged.

module positional_array_engine
  import pae_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    in_cmd_i,
  input  logic [POS_W-1:0]    in_position_i,
  input  logic [DATA_W-1:0]   in_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [FOUND_W-1:0]  out_found_index_o,
  output logic [DATA_W-1:0]   out_read_value_o,
  output logic [COUNT_W-1:0]  out_entry_count_o
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int CmpW = (CntW > POS_W) ? CntW : POS_W;

  cell_ctl_t           ctl;
  logic [CmpW-1:0]     pos;
  logic [CmpW-1:0]     count;
  logic [DATA_W-1:0]   value;
  logic [CAPACITY-1:0] match;
  logic [DATA_W-1:0]   rd_word;

  logic [DATA_W-1:0] entry   [CAPACITY];
  logic [DATA_W-1:0] rd_tap  [CAPACITY];
  logic [DATA_W-1:0] left_w  [CAPACITY];
  logic [DATA_W-1:0] right_w [CAPACITY];

  pae_ctrl #(
    .Capacity (CAPACITY),
    .CmpW     (CmpW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_cmd_i          (in_cmd_i),
    .in_position_i     (in_position_i),
    .in_value_i        (in_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_status_o      (out_status_o),
    .out_found_index_o (out_found_index_o),
    .out_read_value_o  (out_read_value_o),
    .out_entry_count_o (out_entry_count_o),
    .ctl_o             (ctl),
    .pos_o             (pos),
    .count_o           (count),
    .value_o           (value),
    .match_i           (match),
    .rd_word_i         (rd_word)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    // neighbour links; the ends of the row see zero
    if (g == 0) begin : g_first
      assign left_w[g] = '0;
    end else begin : g_left
      assign left_w[g] = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w[g] = '0;
    end else begin : g_right
      assign right_w[g] = entry[g+1];
    end

    pae_cell #(
      .Idx  (g),
      .CmpW (CmpW)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .pos_i    (pos),
      .count_i  (count),
      .value_i  (value),
      .left_i   (left_w[g]),
      .right_i  (right_w[g]),
      .entry_o  (entry[g]),
      .match_o  (match[g]),
      .rd_tap_o (rd_tap[g])
    );
  end

  // at most one cell taps out, so an or across the row selects it
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | rd_tap[i];
    end
  end

endmodule
